/* hw/rtl/tll_pkg.sv */
// Shared types and constants for the table lerp lookup block.
`default_nettype none
package tll_pkg;

    localparam int CNT_W      = 9;
    localparam int ADDR_W     = 8;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_COUNT = 2'd0,
        CFG_CLAMP_MODE  = 2'd1,
        CFG_SNAP_MODE   = 2'd2
    } t_cfg_reg;

    // per-stage control that travels with each word
    typedef struct packed {
        logic vld;
        logic op;
        logic unity;
        logic snap;
    } t_ctl;

endpackage
`default_nettype wire

/* hw/rtl/tll_scale.sv */
// Index scaling pipeline: scale multiply, clamp or wrap, entry select.
`default_nettype none
module tll_scale #(
    parameter int FRAC_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  wire                              i_valid,
    input  wire                              i_op,
    input  wire [tll_pkg::ADDR_W-1:0]        i_entry_address,
    input  wire signed [tll_pkg::DATA_W-1:0] i_entry_value,
    input  wire signed [31:0]                i_lookup_index,
    input  wire [tll_pkg::CNT_W-1:0]         i_count,
    input  wire                              i_clamp,
    input  wire                              i_snap,
    output tll_pkg::t_ctl                    o_ctl,
    output logic [tll_pkg::CNT_W-1:0]        o_idx,
    output logic [tll_pkg::CNT_W-1:0]        o_nxt,
    output logic [FRAC_BITS-1:0]             o_frac,
    output logic [tll_pkg::ADDR_W-1:0]       o_wr_addr,
    output logic [tll_pkg::DATA_W-1:0]       o_wr_data
);

    localparam int OPW = 33;
    localparam int MW  = tll_pkg::CNT_W + 1;
    localparam int PW  = OPW + MW;

    // stage 1: input register
    tll_pkg::t_ctl                r_s1_ctl;
    logic signed [31:0]           r_s1_x;
    logic [tll_pkg::ADDR_W-1:0]   r_s1_addr;
    logic [tll_pkg::DATA_W-1:0]   r_s1_data;

    // stage 2: scaled index
    tll_pkg::t_ctl                r_s2_ctl;
    logic signed [PW-1:0]         r_s2_p;
    logic [tll_pkg::ADDR_W-1:0]   r_s2_addr;
    logic [tll_pkg::DATA_W-1:0]   r_s2_data;

    // stage 3: entry select
    tll_pkg::t_ctl                r_s3_ctl;
    logic [tll_pkg::CNT_W-1:0]    r_s3_idx;
    logic [tll_pkg::CNT_W-1:0]    r_s3_nxt;
    logic [FRAC_BITS-1:0]         r_s3_frac;
    logic [tll_pkg::ADDR_W-1:0]   r_s3_addr;
    logic [tll_pkg::DATA_W-1:0]   r_s3_data;

    logic [tll_pkg::CNT_W-1:0]    w_nm1;
    logic signed [OPW-1:0]        w_opnd;
    logic signed [MW-1:0]         w_mul;
    tll_pkg::t_ctl                n_s2_ctl;
    logic [PW-1:0]                w_lim;
    logic                         w_hi;
    logic                         w_lo;
    logic [tll_pkg::CNT_W-1:0]    n_s3_idx;
    logic [tll_pkg::CNT_W:0]      w_inc;
    logic [tll_pkg::CNT_W-1:0]    n_s3_nxt;
    logic [FRAC_BITS-1:0]         n_s3_frac;

    assign w_nm1 = i_count - tll_pkg::CNT_W'(1);

    // clamp scales the whole index by n-1; wrap only needs the fraction times n
    always_comb begin
        if (i_clamp) begin
            w_opnd = {r_s1_x[31], r_s1_x};
            w_mul  = {1'b0, w_nm1};
        end else begin
            w_opnd = {{(OPW-FRAC_BITS){1'b0}}, r_s1_x[FRAC_BITS-1:0]};
            w_mul  = {1'b0, i_count};
        end
        n_s2_ctl       = r_s1_ctl;
        n_s2_ctl.unity = (i_count <= tll_pkg::CNT_W'(1));
    end

    assign w_lim = {{(PW-tll_pkg::CNT_W-FRAC_BITS){1'b0}}, w_nm1, {FRAC_BITS{1'b0}}};
    assign w_hi  = i_clamp && (r_s2_p >= $signed(w_lim));
    assign w_lo  = i_clamp && !w_hi && (r_s2_p[PW-1] || (r_s2_p == '0));

    always_comb begin
        if (w_hi) begin
            n_s3_idx  = w_nm1;
            n_s3_frac = '0;
        end else if (w_lo) begin
            n_s3_idx  = '0;
            n_s3_frac = '0;
        end else begin
            n_s3_idx  = r_s2_p[FRAC_BITS+tll_pkg::CNT_W-1:FRAC_BITS];
            n_s3_frac = r_s2_p[FRAC_BITS-1:0];
        end
        w_inc = {1'b0, n_s3_idx} + (tll_pkg::CNT_W+1)'(1);
        if (w_inc >= {1'b0, i_count}) begin
            n_s3_nxt = '0;
        end else begin
            n_s3_nxt = w_inc[tll_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else if (i_adv) begin
            r_s1_ctl <= '{vld: i_valid, op: i_op, unity: 1'b0, snap: i_snap};
            r_s2_ctl <= n_s2_ctl;
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_x    <= i_lookup_index;
            r_s1_addr <= i_entry_address;
            r_s1_data <= i_entry_value;
            r_s2_p    <= w_opnd * w_mul;
            r_s2_addr <= r_s1_addr;
            r_s2_data <= r_s1_data;
            r_s3_idx  <= n_s3_idx;
            r_s3_nxt  <= n_s3_nxt;
            r_s3_frac <= n_s3_frac;
            r_s3_addr <= r_s2_addr;
            r_s3_data <= r_s2_data;
        end
    end

    assign o_ctl     = r_s3_ctl;
    assign o_idx     = r_s3_idx;
    assign o_nxt     = r_s3_nxt;
    assign o_frac    = r_s3_frac;
    assign o_wr_addr = r_s3_addr;
    assign o_wr_data = r_s3_data;

endmodule
`default_nettype wire

/* hw/rtl/tll_mem.sv */
// Table storage: one write port and two registered read ports.
`default_nettype none
module tll_mem #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire                         i_clk,
    input  wire                         i_adv,
    input  wire                         i_we,
    input  wire [tll_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire [tll_pkg::DATA_W-1:0]   i_wr_data,
    input  wire [tll_pkg::CNT_W-1:0]    i_rd_idx_a,
    input  wire [tll_pkg::CNT_W-1:0]    i_rd_idx_b,
    output logic [tll_pkg::DATA_W-1:0]  o_rd_a,
    output logic [tll_pkg::DATA_W-1:0]  o_rd_b
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [tll_pkg::DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic [tll_pkg::DATA_W-1:0] r_rd_a;
    logic [tll_pkg::DATA_W-1:0] r_rd_b;

    logic [31:0] w_wa_ext;
    logic [31:0] w_ra_ext;
    logic [31:0] w_rb_ext;
    logic        w_wr_ok;

    assign w_wa_ext = 32'(i_wr_addr);
    assign w_ra_ext = 32'(i_rd_idx_a);
    assign w_rb_ext = 32'(i_rd_idx_b);
    // slots beyond the table drop the write
    assign w_wr_ok  = i_we && (w_wa_ext < 32'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_wr_ok) begin
                r_mem[w_wa_ext[AW-1:0]] <= i_wr_data;
            end
            r_rd_a <= r_mem[w_ra_ext[AW-1:0]];
            r_rd_b <= r_mem[w_rb_ext[AW-1:0]];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule
`default_nettype wire

/* hw/rtl/tll_blend.sv */
// Blend pipeline: weight multiplies, sum, floor shift and output register.
`default_nettype none
module tll_blend #(
    parameter int FRAC_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  tll_pkg::t_ctl                    i_ctl,
    input  wire [FRAC_BITS-1:0]              i_frac,
    input  wire signed [tll_pkg::DATA_W-1:0] i_a,
    input  wire signed [tll_pkg::DATA_W-1:0] i_b,
    output logic                             o_valid,
    output logic signed [tll_pkg::DATA_W-1:0] o_value
);

    localparam int WW  = FRAC_BITS + 2;
    localparam int PRW = tll_pkg::DATA_W + WW;
    localparam int SW  = PRW + 1;
    localparam logic [tll_pkg::DATA_W-1:0] UNITY = tll_pkg::DATA_W'(1) << FRAC_BITS;

    // stage 4: lines up with the memory read data
    tll_pkg::t_ctl                   r_s4_ctl;
    logic [FRAC_BITS-1:0]            r_s4_frac;

    // stage 5: weighted products
    tll_pkg::t_ctl                   r_s5_ctl;
    logic signed [PRW-1:0]           r_s5_pa;
    logic signed [PRW-1:0]           r_s5_pb;
    logic [tll_pkg::DATA_W-1:0]      r_s5_a;

    // stage 6: output word
    logic                            r_out_vld;
    logic [tll_pkg::DATA_W-1:0]      r_out_value;

    logic signed [WW-1:0]            w_wa;
    logic signed [WW-1:0]            w_wb;
    logic signed [SW-1:0]            w_sum;
    logic [tll_pkg::DATA_W-1:0]      n_out_value;

    assign w_wa  = {1'b0, 1'b1, {FRAC_BITS{1'b0}}} - {2'b00, r_s4_frac};
    assign w_wb  = {2'b00, r_s4_frac};
    assign w_sum = SW'(r_s5_pa) + SW'(r_s5_pb);

    always_comb begin
        if (r_s5_ctl.unity) begin
            n_out_value = UNITY;
        end else if (r_s5_ctl.snap) begin
            n_out_value = r_s5_a;
        end else begin
            // arithmetic shift right is a floor divide
            n_out_value = w_sum[FRAC_BITS+tll_pkg::DATA_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl  <= '0;
            r_s5_ctl  <= '0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_s4_ctl  <= i_ctl;
            r_s5_ctl  <= r_s4_ctl;
            r_out_vld <= r_s5_ctl.vld && (r_s5_ctl.op == tll_pkg::OP_LOOKUP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s4_frac   <= i_frac;
            r_s5_pa     <= i_a * w_wa;
            r_s5_pb     <= i_b * w_wb;
            r_s5_a      <= i_a;
            r_out_value <= n_out_value;
        end
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out_value;

endmodule
`default_nettype wire

/* hw/rtl/table_lerp_lookup_top.sv */
// A lookup passes stages 1 to 5 and the output register; one word per cycle
// moves on while o_stall is low. The single scale multiplier, the two-port
// table read and the two blend multipliers each sit in a stage of their own.
// Table writes take effect in order with lookups, at the table read stage.
// Reset (synchronous, active low) clears the config registers and pipeline
// valids; table contents are left as they are and need no clearing pass.
`default_nettype none
module table_lerp_lookup_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [tll_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [tll_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire                                  i_op,
    input  wire [tll_pkg::ADDR_W-1:0]            i_entry_address,
    input  wire signed [tll_pkg::DATA_W-1:0]     i_entry_value,
    input  wire signed [31:0]                    i_lookup_index,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [tll_pkg::DATA_W-1:0]    o_result_value
);

    logic [tll_pkg::CNT_W-1:0]   r_entry_count;
    logic                        r_clamp_mode;
    logic                        r_snap_mode;

    logic [tll_pkg::CNT_W-1:0]   w_count;
    logic                        w_adv;
    tll_pkg::t_ctl               w_s3_ctl;
    logic [tll_pkg::CNT_W-1:0]   w_idx;
    logic [tll_pkg::CNT_W-1:0]   w_nxt;
    logic [FRAC_BITS-1:0]        w_frac;
    logic [tll_pkg::ADDR_W-1:0]  w_wr_addr;
    logic [tll_pkg::DATA_W-1:0]  w_wr_data;
    logic [tll_pkg::DATA_W-1:0]  w_rd_a;
    logic [tll_pkg::DATA_W-1:0]  w_rd_b;
    logic                        w_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_clamp_mode  <= 1'b0;
            r_snap_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (tll_pkg::t_cfg_reg'(i_cfg_index))
                tll_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                tll_pkg::CFG_CLAMP_MODE:  r_clamp_mode  <= i_cfg_data[0];
                tll_pkg::CFG_SNAP_MODE:   r_snap_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // counts above the table size act as the table size
    always_comb begin
        if (32'(r_entry_count) > TABLE_DEPTH) begin
            w_count = tll_pkg::CNT_W'(TABLE_DEPTH);
        end else begin
            w_count = r_entry_count;
        end
    end

    // whole pipeline moves together; only a held output word stops it
    assign w_adv   = !w_out_vld || !i_stall;
    assign o_stall = !w_adv;

    tll_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_valid         (i_valid),
        .i_op            (i_op),
        .i_entry_address (i_entry_address),
        .i_entry_value   (i_entry_value),
        .i_lookup_index  (i_lookup_index),
        .i_count         (w_count),
        .i_clamp         (r_clamp_mode),
        .i_snap          (r_snap_mode),
        .o_ctl           (w_s3_ctl),
        .o_idx           (w_idx),
        .o_nxt           (w_nxt),
        .o_frac          (w_frac),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data)
    );

    tll_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_adv      (w_adv),
        .i_we       (w_s3_ctl.vld && (w_s3_ctl.op == tll_pkg::OP_WRITE)),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_idx_a (w_idx),
        .i_rd_idx_b (w_nxt),
        .o_rd_a     (w_rd_a),
        .o_rd_b     (w_rd_b)
    );

    tll_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_s3_ctl),
        .i_frac  (w_frac),
        .i_a     (w_rd_a),
        .i_b     (w_rd_b),
        .o_valid (w_out_vld),
        .o_value (o_result_value)
    );

    assign o_valid = w_out_vld;

endmodule
`default_nettype wire
